// File: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property that is checked only outside reset.
`define ASSERT_OFF_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/stfl_pkg.sv
// Package with request codes, status codes and the packet that moves along the cell chain.
package stfl_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Request plus the running result that each cell refines.
  typedef struct packed {
    req_t        req_type;
    logic [31:0] address;
    logic [63:0] name_tag;
    logic [31:0] line_number;
    logic        dup;        // an earlier cell holds the same name and address
    logic        saw_empty;  // an empty cell has been passed
    logic        placed;     // the entry was written into a cell
    logic        have;       // a lookup candidate has been found
    logic [31:0] best_addr;
    logic [63:0] best_name;
    logic [31:0] best_line;
  } stfl_pkt_t;

endpackage

// File: src/stfl_cell.sv
// One table cell: holds one entry and refines the passing request by one step.
module stfl_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  stfl_pkg::stfl_pkt_t in_pkt,
  output logic               out_valid,
  output stfl_pkg::stfl_pkt_t out_pkt
);
  import stfl_pkg::*;

  logic        ent_valid;
  logic [31:0] ent_addr;
  logic [63:0] ent_name;
  logic [31:0] ent_line;

  logic      is_ins;
  logic      match;
  logic      place;
  logic      take;
  stfl_pkt_t out_pkt_next;

  // Compare the held entry against the request
  always_comb begin
    is_ins = (in_pkt.req_type == REQ_INSERT);
    match  = ent_valid && (ent_addr == in_pkt.address) && (ent_name == in_pkt.name_tag);
    place  = is_ins && !ent_valid && !in_pkt.dup && !in_pkt.saw_empty;
    take   = !is_ins && ent_valid && (ent_addr < in_pkt.address) &&
             (!in_pkt.have || (ent_addr > in_pkt.best_addr));
  end

  // Update the running result; strict compare keeps the earliest on ties
  always_comb begin
    out_pkt_next = in_pkt;
    if (is_ins) begin
      out_pkt_next.dup       = in_pkt.dup | match;
      out_pkt_next.saw_empty = in_pkt.saw_empty | !ent_valid;
      out_pkt_next.placed    = in_pkt.placed | place;
    end
    if (take) begin
      out_pkt_next.have      = 1'b1;
      out_pkt_next.best_addr = ent_addr;
      out_pkt_next.best_name = ent_name;
      out_pkt_next.best_line = ent_line;
    end
  end

  // Fill the cell once, on the first insert that reaches it empty with no duplicate or empty cell before it
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (advance && in_valid && place) begin
      ent_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && place) begin
      ent_addr <= in_pkt.address;
      ent_name <= in_pkt.name_tag;
      ent_line <= in_pkt.line_number;
    end
  end

  // Hand the request to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pkt <= out_pkt_next;
    end
  end

endmodule

// File: src/symbol_table_floor_lookup.sv
// Symbol table top level: a chain of TABLE_DEPTH cells, one entry each, and a result register.
// Every request walks the chain of TABLE_DEPTH cells, one cell per cycle while the chain
// advances, and its result is registered. Requests follow each other in every cycle while no
// result is stalled; a later request reaches each cell after every earlier one, so it sees all
// earlier inserts. The whole chain holds while a result waits at the output, and in_ready is
// low then. Inserts fill cells in order; the first empty cell takes the entry unless a duplicate
// was seen before it, and a request that passes no empty cell reports a full table. Lookups keep
// the greatest address below the query, the earliest cell winning ties. Reset empties the table.
module symbol_table_floor_lookup #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] address,
  input  logic [63:0] name_tag,
  input  logic [31:0] line_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] hit_address,
  output logic [63:0] hit_name,
  output logic [31:0] hit_line
);
  import stfl_pkg::*;

  logic      advance;
  logic      vld [TABLE_DEPTH+1];
  stfl_pkt_t pkt [TABLE_DEPTH+1];
  stfl_pkt_t pkt_in;
  status_t   status_next;

  // Move the chain whenever the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Build the entering packet with an empty running result
  always_comb begin
    pkt_in             = '0;
    pkt_in.req_type    = req_t'(req_type);
    pkt_in.address     = address;
    pkt_in.name_tag    = name_tag;
    pkt_in.line_number = line_number;
  end
  assign pkt[0] = pkt_in;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    stfl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (vld[i]),
      .in_pkt   (pkt[i]),
      .out_valid(vld[i+1]),
      .out_pkt  (pkt[i+1])
    );
  end

  // Decide the status from the flags gathered along the chain
  always_comb begin
    if (pkt[TABLE_DEPTH].req_type == REQ_LOOKUP) begin
      status_next = pkt[TABLE_DEPTH].have ? ST_FOUND : ST_NOT_FOUND;
    end else if (pkt[TABLE_DEPTH].placed) begin
      status_next = ST_INSERTED;
    end else if (pkt[TABLE_DEPTH].saw_empty) begin
      status_next = ST_DUPLICATE;
    end else begin
      status_next = ST_FULL;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[TABLE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status      <= status_next;
      hit_address <= pkt[TABLE_DEPTH].best_addr;
      hit_name    <= pkt[TABLE_DEPTH].best_name;
      hit_line    <= pkt[TABLE_DEPTH].best_line;
    end
  end

endmodule

// File: src/stfl_checker.sv
// Port checker for the symbol table, bound to the top level.
`include "assert_macros.svh"

module stfl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] hit_address,
  input logic [63:0] hit_name,
  input logic [31:0] hit_line
);
  import stfl_pkg::*;

  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "result shown right after reset")

  `ASSERT_OFF_RST(a_stall_blocks, clk, rst, (out_valid && !out_ready) |-> !in_ready,
    "request taken while a result is stalled")

  `ASSERT_OFF_RST(a_miss_zero, clk, rst,
    (out_valid && (status != ST_FOUND)) |->
      ((hit_address == '0) && (hit_name == '0) && (hit_line == '0)),
    "nonzero hit fields without a found status")

  `ASSERT_OFF_RST(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(hit_address)),
    "stalled result changed")

endmodule

bind symbol_table_floor_lookup stfl_checker u_stfl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .hit_address(hit_address),
  .hit_name   (hit_name),
  .hit_line   (hit_line)
);
